### design/mtd_pkg.sv
// Package for the Morse text decoder: byte constants, field widths and the
// Morse code table lookup. No dependencies.
package mtd_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned SymW     = 7;   // symbols held for a table lookup
  localparam int unsigned LenW     = 4;   // symbol counter, saturating
  localparam int unsigned LenSelW  = 3;   // length field of a lookup key

  localparam logic [LenW-1:0] MaxSymbols = LenW'(SymW);
  localparam logic [LenW-1:0] LenSat     = {LenW{1'b1}};

  localparam logic [CharW-1:0] ChDot    = 8'h2E;
  localparam logic [CharW-1:0] ChDash   = 8'h2D;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChNone   = 8'h00;

  function automatic logic is_space_byte(input logic [CharW-1:0] c);
    return ((c >= ChTab) && (c <= ChCr)) || (c == ChSpace);
  endfunction

  // Symbols are right-aligned, the first symbol in the highest used bit,
  // dot as 0 and dash as 1. Returns zero where no entry matches.
  function automatic logic [CharW-1:0] morse_lookup(input logic [LenSelW-1:0] len,
                                                    input logic [SymW-1:0]    sym);
    logic [CharW-1:0] ch;
    ch = ChNone;
    unique case ({len, sym})
      {3'd2, 7'b0000001}: ch = "A";
      {3'd4, 7'b0001000}: ch = "B";
      {3'd4, 7'b0001010}: ch = "C";
      {3'd3, 7'b0000100}: ch = "D";
      {3'd1, 7'b0000000}: ch = "E";
      {3'd4, 7'b0000010}: ch = "F";
      {3'd3, 7'b0000110}: ch = "G";
      {3'd4, 7'b0000000}: ch = "H";
      {3'd2, 7'b0000000}: ch = "I";
      {3'd4, 7'b0000111}: ch = "J";
      {3'd3, 7'b0000101}: ch = "K";
      {3'd4, 7'b0000100}: ch = "L";
      {3'd2, 7'b0000011}: ch = "M";
      {3'd2, 7'b0000010}: ch = "N";
      {3'd3, 7'b0000111}: ch = "O";
      {3'd4, 7'b0000110}: ch = "P";
      {3'd4, 7'b0001101}: ch = "Q";
      {3'd3, 7'b0000010}: ch = "R";
      {3'd3, 7'b0000000}: ch = "S";
      {3'd1, 7'b0000001}: ch = "T";
      {3'd3, 7'b0000001}: ch = "U";
      {3'd4, 7'b0000001}: ch = "V";
      {3'd3, 7'b0000011}: ch = "W";
      {3'd4, 7'b0001001}: ch = "X";
      {3'd4, 7'b0001011}: ch = "Y";
      {3'd4, 7'b0001100}: ch = "Z";
      {3'd5, 7'b0011111}: ch = "0";
      {3'd5, 7'b0001111}: ch = "1";
      {3'd5, 7'b0000111}: ch = "2";
      {3'd5, 7'b0000011}: ch = "3";
      {3'd5, 7'b0000001}: ch = "4";
      {3'd5, 7'b0000000}: ch = "5";
      {3'd5, 7'b0010000}: ch = "6";
      {3'd5, 7'b0011000}: ch = "7";
      {3'd5, 7'b0011100}: ch = "8";
      {3'd5, 7'b0011110}: ch = "9";
      {3'd6, 7'b0010101}: ch = ".";
      {3'd6, 7'b0110011}: ch = ",";
      {3'd6, 7'b0001100}: ch = "?";
      {3'd6, 7'b0101011}: ch = "!";
      {3'd6, 7'b0100001}: ch = "-";
      {3'd5, 7'b0010010}: ch = "/";
      {3'd6, 7'b0011110}: ch = "'";
      {3'd5, 7'b0010001}: ch = "=";
      {3'd5, 7'b0010110}: ch = "(";
      {3'd6, 7'b0101101}: ch = ")";
      {3'd5, 7'b0001000}: ch = "&";
      {3'd6, 7'b0111000}: ch = ":";
      {3'd5, 7'b0001010}: ch = "+";
      {3'd6, 7'b0001101}: ch = "_";
      {3'd6, 7'b0010010}: ch = "\"";
      {3'd7, 7'b0001001}: ch = "$";
      {3'd6, 7'b0011010}: ch = "@";
      {3'd6, 7'b0101010}: ch = ";";
      default:            ch = ChNone;
    endcase
    return ch;
  endfunction

endpackage

### design/morse_text_decoder.sv
// Morse text decoder top level: input register, code accumulator and
// table lookup into an output register. Depends on mtd_pkg.

// Takes Morse text one byte per request on the slave stream and returns one
// decoded character per whitespace byte (9 to 13 or 32) or end-of-text
// request (tlast), nothing for other bytes. Dots and dashes build the pending
// code; any other byte, or more than seven symbols, makes the code decode to
// character 0 with tuser set. Whitespace with no pending code gives a space.
// The block takes one byte every cycle while the output stream is not stalled:
// a byte is held in the input register, and its character is written to the
// output register when it is processed. Symbol bytes move on during a stall;
// the rate drops only when a whitespace or end-of-text byte meets a stall.
module morse_text_decoder
  import mtd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [CharW-1:0] s_axis_tdata,   // [7:0] in_char
  input  logic             s_axis_tlast,   // end of text (cmd)
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [CharW-1:0] m_axis_tdata,   // [7:0] out_char
  output logic             m_axis_tuser,   // [0] unknown_code
  output logic             m_axis_tlast    // last
);

  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;

  logic [SymW-1:0]  sym_q, sym_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             bad_q, bad_d;

  logic             out_valid_q;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic             out_unk_q, out_unk_d;
  logic             out_last_q;

  logic             out_free;
  logic             is_symbol;
  logic             gives_result;
  logic             fire;
  logic             s_accept;
  logic [CharW-1:0] table_ch;

  assign out_free     = !out_valid_q || m_axis_tready;
  assign is_symbol    = !in_last_q && !is_space_byte(in_char_q);
  assign gives_result = !is_symbol;
  assign fire         = in_valid_q && (is_symbol || out_free);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_accept     = s_axis_tvalid && s_axis_tready;

  assign table_ch = morse_lookup(len_q[LenSelW-1:0], sym_q);

  always_comb begin
    sym_d      = sym_q;
    len_d      = len_q;
    bad_d      = bad_q;
    out_char_d = ChSpace;
    out_unk_d  = 1'b0;
    if (is_symbol) begin
      if ((in_char_q != ChDot) && (in_char_q != ChDash)) begin
        bad_d = 1'b1;
      end
      if (len_q < MaxSymbols) begin
        sym_d = {sym_q[SymW-2:0], in_char_q == ChDash};
      end
      if (len_q != LenSat) begin
        len_d = len_q + LenW'(1);
      end
    end else begin
      if (len_q != '0) begin
        out_char_d = ChNone;
        if (!bad_q && (len_q <= MaxSymbols)) begin
          out_char_d = table_ch;
        end
        out_unk_d = (out_char_d == ChNone);
      end
      sym_d = '0;
      len_d = '0;
      bad_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      sym_q       <= '0;
      len_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (fire) begin
        sym_q <= sym_d;
        len_q <= len_d;
        bad_q <= bad_d;
      end
      if (fire && gives_result) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (fire && gives_result) begin
      out_char_q <= out_char_d;
      out_unk_q  <= out_unk_d;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tuser  = out_unk_q;
  assign m_axis_tlast  = out_last_q;

  // An unknown code always decodes to character zero.
  a_unknown_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == ChNone))
    else $error("unknown code with non-zero character");

  // With no pending symbols the code register and bad flag are clear.
  a_empty_code_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == '0) |-> ((sym_q == '0) && !bad_q))
    else $error("code state not clear while empty");

  // The code state moves only when a held byte is processed.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |=> ($stable(len_q) && $stable(sym_q)))
    else $error("code state changed without a byte");

  // A result stalled at the output blocks only a byte that would give a result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && gives_result && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

endmodule
